@@ hw/rtl/rcwm_pkg.sv @@
// ----------------------------------------------------------------------------
// rcwm_pkg
// Types, constants and the base encoder shared by the complement window matcher.
// ----------------------------------------------------------------------------
package rcwm_pkg;

	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 6;
	localparam int BASES_W    = 64;
	localparam int COUNT_W    = 11;
	localparam int POS_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BASES  = 2'd1;

	localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_U = 8'h55;

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_U = 2'd3;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_enc_t;

	// window control from the sequencing logic
	typedef struct packed {
		logic       step;
		logic       clear;
		logic       ok;
		logic [1:0] code;
	} win_ctl_t;

	function automatic base_enc_t encode_base(input logic [CHAR_W-1:0] ch);
		base_enc_t r;
		r.ok   = 1'b1;
		r.code = CODE_A;
		unique case (ch)
			CHAR_A: r.code = CODE_A;
			CHAR_C: r.code = CODE_C;
			CHAR_G: r.code = CODE_G;
			CHAR_U: r.code = CODE_U;
			default: r.ok  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/rcwm_if.sv @@
// ----------------------------------------------------------------------------
// rcwm_if
// Valid/ready channels for sequence characters and match results.
// ----------------------------------------------------------------------------
interface rcwm_in_if;
	logic                        valid;
	logic                        ready;
	logic [rcwm_pkg::CHAR_W-1:0] base_char;
	logic                        is_last;

	modport source (output valid, base_char, is_last, input ready);
	modport sink   (input valid, base_char, is_last, output ready);
endinterface

interface rcwm_out_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [rcwm_pkg::POS_W-1:0] match_position;

	modport source (output valid, found, match_position, input ready);
	modport sink   (input valid, found, match_position, output ready);
endinterface

@@ hw/rtl/rcwm_window.sv @@
// ----------------------------------------------------------------------------
// rcwm_window
// Shift register of recent bases and parallel complement compare per lane.
// ----------------------------------------------------------------------------
module rcwm_window #(
	parameter int DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcwm_pkg::win_ctl_t            ctl,
	input  logic [rcwm_pkg::LEN_W-1:0]    len,
	input  logic [rcwm_pkg::BASES_W-1:0]  bases,
	output logic                          match
);

	logic [DEPTH-1:0] valid_q;
	logic [1:0]       code_q  [DEPTH];
	logic [DEPTH-1:0] nvalid;
	logic [1:0]       ncode   [DEPTH];
	logic [DEPTH-1:0] mism;

	// lane 0 takes the newest base; it pairs with oligo base 0
	always_comb begin
		nvalid[0] = ctl.ok;
		ncode[0]  = ctl.code;
		for (int k = 1; k < DEPTH; k++) begin
			nvalid[k] = valid_q[k-1];
			ncode[k]  = code_q[k-1];
		end
		for (int k = 0; k < DEPTH; k++) begin
			mism[k] = (rcwm_pkg::LEN_W'(k) < len) &&
			          (!nvalid[k] || ncode[k] != ~bases[2*k +: 2]);
		end
	end

	assign match = ~|mism;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.step) begin
			if (ctl.clear) begin
				valid_q <= '0;
			end else begin
				valid_q <= nvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			for (int k = 0; k < DEPTH; k++) begin
				code_q[k] <= ncode[k];
			end
		end
	end

endmodule

@@ hw/rtl/rna_complement_window_match_core.sv @@
// ----------------------------------------------------------------------------
// rna_complement_window_match_core
// Finds the first window of an RNA stream that pairs with a reversed oligo.
// ----------------------------------------------------------------------------
// Takes one character per cycle with no bubbles, except while a last item waits
// for the result register; each accepted item passes the input register, then
// the combinational compare of all window lanes against the oligo into the
// result register, so a report is offered once its last item leaves the input
// register. Only the item marked last yields a result; while that
// result waits to be taken, further items still flow until the next last
// item needs the result register. The oligo registers are to be written only
// while no item is in flight; the user must keep to this, the block does not enforce it.
module rna_complement_window_match_core #(
	parameter int MAX_PATTERN  = 32,
	parameter int MAX_SEQUENCE = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rcwm_in_if.sink                          item_in,
	rcwm_out_if.source                       result_out,
	input  logic                             cfg_wr_en,
	input  logic [rcwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam logic [rcwm_pkg::LEN_W-1:0] LenMax = rcwm_pkg::LEN_W'(MAX_PATTERN);
	localparam longint unsigned SeqLast = longint'(MAX_SEQUENCE) - 1;
	localparam logic [rcwm_pkg::COUNT_W:0] PosClamp =
		(SeqLast > 4095) ? '1 : (rcwm_pkg::COUNT_W+1)'(SeqLast);

	logic [rcwm_pkg::LEN_W-1:0]   pattern_length_q;
	logic [rcwm_pkg::BASES_W-1:0] pattern_bases_q;
	logic [rcwm_pkg::LEN_W-1:0]   len;

	rcwm_pkg::base_enc_t enc;
	logic       valid_s1;
	logic       ok_s1;
	logic [1:0] code_s1;
	logic       last_s1;
	logic       adv;

	logic [rcwm_pkg::COUNT_W-1:0] chars_seen_q;
	logic                         hit_valid_q;
	logic [rcwm_pkg::POS_W-1:0]   hit_pos_q;
	logic                         out_valid_q;
	logic                         found_q;
	logic [rcwm_pkg::POS_W-1:0]   pos_q;

	rcwm_pkg::win_ctl_t           wctl;
	logic                         match;
	logic [rcwm_pkg::COUNT_W:0]   n_plus;
	logic [rcwm_pkg::COUNT_W:0]   start;
	logic [rcwm_pkg::COUNT_W:0]   start_sat;
	logic                         hit_now;
	logic                         hit_next;
	logic [rcwm_pkg::POS_W-1:0]   pos_next;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= rcwm_pkg::LEN_W'(1);
			pattern_bases_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rcwm_pkg::REG_PATTERN_LENGTH:
					pattern_length_q <= cfg_wdata[rcwm_pkg::LEN_W-1:0];
				rcwm_pkg::REG_PATTERN_BASES:
					pattern_bases_q <= cfg_wdata[rcwm_pkg::BASES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pattern_length_q == '0) begin
			len = rcwm_pkg::LEN_W'(1);
		end else if (pattern_length_q > LenMax) begin
			len = LenMax;
		end else begin
			len = pattern_length_q;
		end
	end

	// input register; a last item holds while the result register is occupied and not taken
	assign enc = rcwm_pkg::encode_base(item_in.base_char);
	assign adv = valid_s1 && !(last_s1 && out_valid_q && !result_out.ready);
	assign item_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			ok_s1   <= enc.ok;
			code_s1 <= enc.code;
			last_s1 <= item_in.is_last;
		end
	end

	assign wctl.step  = adv;
	assign wctl.clear = last_s1;
	assign wctl.ok    = ok_s1;
	assign wctl.code  = code_s1;

	rcwm_window #(
		.DEPTH (MAX_PATTERN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.len    (len),
		.bases  (pattern_bases_q),
		.match  (match)
	);

	// first hit tracking
	always_comb begin
		n_plus    = {1'b0, chars_seen_q} + (rcwm_pkg::COUNT_W+1)'(1);
		start     = n_plus - (rcwm_pkg::COUNT_W+1)'(len);
		start_sat = (start > PosClamp) ? PosClamp : start;
		hit_now   = !hit_valid_q && match && (n_plus >= (rcwm_pkg::COUNT_W+1)'(len));
		hit_next  = hit_valid_q || hit_now;
		pos_next  = hit_valid_q ? hit_pos_q : start_sat[rcwm_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_seen_q <= '0;
			hit_valid_q  <= 1'b0;
			hit_pos_q    <= '0;
		end else if (adv) begin
			if (last_s1) begin
				chars_seen_q <= '0;
				hit_valid_q  <= 1'b0;
				hit_pos_q    <= '0;
			end else begin
				if (chars_seen_q < rcwm_pkg::COUNT_MAX) begin
					chars_seen_q <= chars_seen_q + rcwm_pkg::COUNT_W'(1);
				end
				if (hit_now) begin
					hit_valid_q <= 1'b1;
					hit_pos_q   <= pos_next;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			found_q <= hit_next;
			pos_q   <= hit_next ? pos_next : '0;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.found          = found_q;
	assign result_out.match_position = pos_q;

	// checks
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last_s1))
		else $error("result raised without a last item");

	a_none_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (pos_q == '0))
		else $error("position nonzero without a hit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (chars_seen_q == '0 && !hit_valid_q))
		else $error("sequence state not cleared after last item");

	a_hit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_valid_q && !(adv && last_s1)) |=> (hit_valid_q && $stable(hit_pos_q)))
		else $error("first hit overwritten");

endmodule

@@ tb/rna_complement_window_match_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_complement_window_match_core_tb
// Streams RNA character sequences through the window matcher and checks each
// end-of-sequence report (found flag and first start position) against a
// cycle-free model of the pairing window. The run covers short directed
// sequences, random sequences with planted complements under several oligo
// settings and pacing modes, and one sequence longer than the position range.
// ----------------------------------------------------------------------------
module rna_complement_window_match_core_tb;

	localparam int WINDOW_DEPTH = 32;
	localparam int SEQ_SPAN     = 1024;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 20;

	// index outside the register map; a write there must change nothing
	localparam logic [rcwm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic                       found;
		logic [rcwm_pkg::POS_W-1:0] position;
	} match_report_t;

	class window_match_scoreboard;
		logic [rcwm_pkg::LEN_W-1:0]   len_reg;
		logic [rcwm_pkg::BASES_W-1:0] oligo;
		logic                         win_ok[WINDOW_DEPTH];
		logic [1:0]                   win_code[WINDOW_DEPTH];
		int                           seen;
		logic                         hit;
		logic [rcwm_pkg::POS_W-1:0]   hit_pos;
		match_report_t                expected_reports[$];
		int                           errors;
		int                           items;
		int                           sequences;
		int                           checked;

		function new();
			len_reg   = 1;
			oligo     = '0;
			errors    = 0;
			items     = 0;
			sequences = 0;
			checked   = 0;
			clear_sequence();
		endfunction

		function void clear_sequence();
			for (int d = 0; d < WINDOW_DEPTH; d++) begin
				win_ok[d]   = 1'b0;
				win_code[d] = rcwm_pkg::CODE_A;
			end
			seen    = 0;
			hit     = 1'b0;
			hit_pos = '0;
		endfunction

		function void write_reg(logic [rcwm_pkg::CFG_IDX_W-1:0] idx,
				logic [rcwm_pkg::CFG_DATA_W-1:0] val);
			if (idx == rcwm_pkg::REG_PATTERN_LENGTH)
				len_reg = val[rcwm_pkg::LEN_W-1:0];
			else if (idx == rcwm_pkg::REG_PATTERN_BASES)
				oligo = val;
		endfunction

		function int span();
			if (len_reg == 0)
				return 1;
			if (len_reg > WINDOW_DEPTH)
				return WINDOW_DEPTH;
			return int'(len_reg);
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// shift the character in, test the window ending at it, report on the last
		function void take_char(logic [rcwm_pkg::CHAR_W-1:0] ch, logic last);
			logic          ok;
			logic [1:0]    code;
			logic [1:0]    want;
			logic          match;
			int            len;
			int            start;
			match_report_t rep;
			ok   = 1'b1;
			code = rcwm_pkg::CODE_A;
			case (ch)
				rcwm_pkg::CHAR_A: code = rcwm_pkg::CODE_A;
				rcwm_pkg::CHAR_C: code = rcwm_pkg::CODE_C;
				rcwm_pkg::CHAR_G: code = rcwm_pkg::CODE_G;
				rcwm_pkg::CHAR_U: code = rcwm_pkg::CODE_U;
				default: ok = 1'b0;
			endcase
			len = span();
			for (int d = WINDOW_DEPTH - 1; d > 0; d--) begin
				win_ok[d]   = win_ok[d-1];
				win_code[d] = win_code[d-1];
			end
			win_ok[0]   = ok;
			win_code[0] = code;
			items++;
			if (!hit) begin
				match = 1'b1;
				for (int k = 0; k < len; k++) begin
					want = oligo[2*k +: 2] ^ 2'b11;
					if (!win_ok[k] || win_code[k] != want)
						match = 1'b0;
				end
				if (match && seen + 1 >= len) begin
					start = seen + 1 - len;
					if (start > SEQ_SPAN - 1)
						start = SEQ_SPAN - 1;
					hit     = 1'b1;
					hit_pos = start[rcwm_pkg::POS_W-1:0];
				end
			end
			if (seen < rcwm_pkg::COUNT_MAX)
				seen++;
			if (last) begin
				rep.found    = hit;
				rep.position = hit ? hit_pos : '0;
				expected_reports.push_back(rep);
				sequences++;
				clear_sequence();
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic found, logic [rcwm_pkg::POS_W-1:0] position);
			match_report_t exp;
			if (expected_reports.size() == 0) begin
				report($sformatf("report found=%0b position=%0d with none outstanding",
					found, position));
				return;
			end
			exp = expected_reports.pop_front();
			checked++;
			if (found !== exp.found)
				report($sformatf("found %0b, expected %0b", found, exp.found));
			if (position !== exp.position)
				report($sformatf("match_position %0d, expected %0d", position, exp.position));
		endtask
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [rcwm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rcwm_pkg::CFG_DATA_W-1:0] cfg_wdata;

	rcwm_in_if  item_if();
	rcwm_out_if res_if();

	rna_complement_window_match_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (res_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	window_match_scoreboard          sb;
	logic [rcwm_pkg::CHAR_W-1:0]     seq_buf[$];
	int                              send_idle_pct;
	int                              stall_pct;
	int                              cycle_count = 0;
	int                              settings;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// take reports, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.found, res_if.match_position);
		res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [rcwm_pkg::CHAR_W-1:0] base_char(logic [1:0] code);
		case (code)
			rcwm_pkg::CODE_A: return rcwm_pkg::CHAR_A;
			rcwm_pkg::CODE_C: return rcwm_pkg::CHAR_C;
			rcwm_pkg::CODE_G: return rcwm_pkg::CHAR_G;
			default: return rcwm_pkg::CHAR_U;
		endcase
	endfunction

	function automatic logic [rcwm_pkg::CHAR_W-1:0] filler();
		logic [rcwm_pkg::CHAR_W-1:0] r;
		logic [1:0]                  c;
		r = rcwm_pkg::CHAR_W'($urandom_range(0, 255));
		c = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 7) == 0)
			return r;
		return base_char(c);
	endfunction

	task automatic set_pacing(int mode);
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 52; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 52; end
			default: begin send_idle_pct = 31; stall_pct = 31; end
		endcase
	endtask

	task automatic send_item(logic [rcwm_pkg::CHAR_W-1:0] ch, logic last);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_if.valid     <= 1'b1;
		item_if.base_char <= ch;
		item_if.is_last   <= last;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		sb.take_char(ch, last);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], i == s.len() - 1);
	endtask

	task automatic flush_seq();
		for (int i = 0; i < seq_buf.size(); i++)
			send_item(seq_buf[i], i == seq_buf.size() - 1);
		seq_buf.delete();
	endtask

	// drop the input, drain outstanding reports, then let the pipeline empty
	task automatic wait_idle();
		item_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [rcwm_pkg::CFG_IDX_W-1:0] idx,
			logic [rcwm_pkg::CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [rcwm_pkg::CFG_DATA_W-1:0] len,
			logic [rcwm_pkg::CFG_DATA_W-1:0] bases);
		wait_idle();
		write_reg(rcwm_pkg::REG_PATTERN_LENGTH, len);
		write_reg(rcwm_pkg::REG_PATTERN_BASES, bases);
		settings++;
	endtask

	// append the reverse complement of the oligo, optionally with one base spoilt
	task automatic plant(logic spoil);
		int                           len;
		int                           bad;
		logic [rcwm_pkg::BASES_W-1:0] sh;
		logic [1:0]                   c;
		logic [1:0]                   flip;
		logic [rcwm_pkg::CHAR_W-1:0]  ch;
		len = sb.span();
		bad = $urandom_range(0, len - 1);
		for (int j = 0; j < len; j++) begin
			sh   = sb.oligo >> (2 * (len - 1 - j));
			c    = sh[1:0] ^ 2'b11;
			flip = 2'($urandom_range(1, 3));
			ch   = base_char(c);
			if (spoil && j == bad)
				ch = ($urandom_range(0, 1) == 0) ? base_char(c ^ flip) : 8'h4E;
			seq_buf.push_back(ch);
		end
	endtask

	task automatic run_sequence();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 16))
				seq_buf.push_back(rcwm_pkg::CHAR_W'($urandom_range(0, 255)));
		end else if (kind == 9) begin
			repeat ($urandom_range(1, 3))
				seq_buf.push_back(filler());
		end else begin
			repeat ($urandom_range(0, 12))
				seq_buf.push_back(filler());
			plant(kind == 7 || kind == 8);
			repeat ($urandom_range(0, 8))
				seq_buf.push_back(filler());
			if (kind == 5 || kind == 6)
				plant(1'b0);
		end
		flush_seq();
	endtask

	initial begin
		logic [rcwm_pkg::CFG_DATA_W-1:0] junk;
		logic [rcwm_pkg::CHAR_W-1:0]     ch;
		int                              first_item;
		sb            = new();
		send_idle_pct = 0;
		stall_pct     = 0;
		settings      = 0;
		arst_n            <= 1'b0;
		item_if.valid     <= 1'b0;
		item_if.base_char <= '0;
		item_if.is_last   <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_index         <= '0;
		cfg_wdata         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset oligo is a single A, so only U pairs
		set_pacing(0);
		send_text("U");
		send_text("A");
		send_text("GCU");
		wait_idle();
		junk = {$urandom(), $urandom()};
		write_reg(REG_UNUSED, junk);
		send_text("AU");

		// length field of zero with the upper data bits set; oligo of all U
		configure(64'hFFFF_FFFF_FFFF_FFC0, '1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(rcwm_pkg::CHAR_A, 1'b1);

		// oligo A C G: a window too short for it, then a hit followed by a later one
		junk = {$urandom(), $urandom()};
		configure(3, {junk[63:6], rcwm_pkg::CODE_G, rcwm_pkg::CODE_C, rcwm_pkg::CODE_A});
		send_text("GU");
		send_text("CGUCGU");

		configure(63, {$urandom(), $urandom()});
		send_text("A");

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: configure(1, {$urandom(), $urandom()});
				1: configure(32, {$urandom(), $urandom()});
				2: configure({$urandom(), $urandom()} & ~64'h3F, '0);
				3: configure(63, '1);
				4: configure(33, {$urandom(), $urandom()});
				5: configure(64'($urandom_range(2, 8)), {$urandom(), $urandom()});
				6: configure(64'($urandom_range(9, 31)), {$urandom(), $urandom()});
				default: configure(64'($urandom_range(0, 63)), {$urandom(), $urandom()});
			endcase
			set_pacing(p % 4);
			first_item = sb.items;
			while (sb.items - first_item < PHASE_ITEMS)
				run_sequence();
		end

		// one sequence past the position range: the hit starts beyond the last position
		configure(6, {$urandom(), $urandom()});
		set_pacing(3);
		repeat ($urandom_range(SEQ_SPAN, SEQ_SPAN + 16)) begin
			do
				ch = rcwm_pkg::CHAR_W'($urandom_range(0, 255));
			while (ch inside {rcwm_pkg::CHAR_A, rcwm_pkg::CHAR_C, rcwm_pkg::CHAR_G,
				rcwm_pkg::CHAR_U});
			seq_buf.push_back(ch);
		end
		plant(1'b0);
		seq_buf.push_back(filler());
		flush_seq();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("checked %0d sequence reports from %0d characters over %0d oligo settings",
			sb.checked, sb.items, settings);
		$display("lengths 0 to 63 written; one sequence ran past the position range");
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/rcwm_pkg.sv
hw/rtl/rcwm_if.sv
hw/rtl/rcwm_window.sv
hw/rtl/rna_complement_window_match_core.sv
tb/rna_complement_window_match_core_tb.sv
